### sv/ple_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types, codes and default sizes of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CapacityDef  = 16;
  localparam int ElemWidthDef = 32;

  typedef enum logic [2:0] {
    CMD_ADD_FRONT = 3'd0,
    CMD_ADD_REAR  = 3'd1,
    CMD_DEL_FRONT = 3'd2,
    CMD_DEL_REAR  = 3'd3,
    CMD_INS_POS   = 3'd4,
    CMD_DEL_POS   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Operation broadcast to every cell of the row in the same cycle.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_op_t;

endpackage

### sv/ple_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_cell
// One storage cell of the list row: holds one element and shifts it toward
// either neighbor when an element is inserted or removed in front of it.
// ----------------------------------------------------------------------------
module ple_cell #(
  parameter int ELEM_WIDTH = ple_pkg::ElemWidthDef,
  parameter int IDX_W      = 4,
  parameter int CELL_IDX   = 0
) (
  input  logic                  clk_i,
  input  ple_pkg::cell_op_t     op_i,
  input  logic [IDX_W-1:0]      idx_i,
  input  logic [ELEM_WIDTH-1:0] value_i,
  input  logic [ELEM_WIDTH-1:0] left_i,
  input  logic [ELEM_WIDTH-1:0] right_i,
  output logic [ELEM_WIDTH-1:0] data_o,
  output logic [ELEM_WIDTH-1:0] pick_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  logic [ELEM_WIDTH-1:0] data_q, data_d;
  logic                  hit, above;

  always_comb begin
    hit    = (idx_i == MyIdx);
    above  = (MyIdx > idx_i);
    data_d = data_q;
    if (op_i.ins) begin
      if (hit) begin
        data_d = value_i;
      end else if (above) begin
        data_d = left_i;
      end
    end else if (op_i.rem) begin
      // Cells at and behind the removed slot pull from their right neighbor.
      if (hit || above) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign pick_o = hit ? data_q : '0;

endmodule

### sv/positional_list_engine.sv
`timescale 1ns / 1ps
// A result appears in the output register in the cycle after its request is accepted.
// Throughput: one request per cycle if no result stalls; each insert or delete shifts the row.
// A request is taken while a result waits, as long as that result is taken in the same cycle.
// Reset clears the element count and the output valid; the cell contents are not reset.
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to CAPACITY elements held in a row of shifting cells,
// with add, delete and positional insert/delete requests.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int CAPACITY   = ple_pkg::CapacityDef,
  parameter int ELEM_WIDTH = ple_pkg::ElemWidthDef,
  localparam int CNT_W     = $clog2(CAPACITY + 1),
  localparam int POS_W     = $clog2(CAPACITY + 2)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            cmd_i,
  input  logic [POS_W-1:0]      position_i,
  input  logic [ELEM_WIDTH-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic [ELEM_WIDTH-1:0] removed_value_o,
  output logic [CNT_W-1:0]      length_o,
  output logic                  is_empty_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam logic [CNT_W-1:0] FullCount = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]      count_q, count_d;
  logic                  out_valid_q;
  logic [1:0]            status_q, status_d;
  logic [ELEM_WIDTH-1:0] removed_q, removed_d;
  logic [CNT_W-1:0]      length_q;
  logic                  empty_q;

  ple_pkg::cell_op_t     op;
  logic [IDX_W-1:0]      idx;
  logic                  accept;
  logic                  full, empty;
  logic [CMP_W-1:0]      pos_ext, cnt_ext;
  logic [CNT_W-1:0]      count_m1;
  logic [POS_W-1:0]      pos_m1;
  logic [ELEM_WIDTH-1:0] pick_or;

  logic [ELEM_WIDTH-1:0] cell_data [CAPACITY];
  logic [ELEM_WIDTH-1:0] cell_pick [CAPACITY];

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    full     = (count_q == FullCount);
    empty    = (count_q == '0);
    pos_ext  = CMP_W'(position_i);
    cnt_ext  = CMP_W'(count_q);
    count_m1 = count_q - CNT_W'(1);
    pos_m1   = position_i - POS_W'(1);
    status_d = ple_pkg::ST_OK;
    op       = '0;
    idx      = '0;
    case (cmd_i)
      ple_pkg::CMD_ADD_FRONT: begin
        if (full) begin
          status_d = ple_pkg::ST_FULL;
        end else begin
          op.ins = 1'b1;
        end
      end
      ple_pkg::CMD_ADD_REAR: begin
        idx = count_q[IDX_W-1:0];
        if (full) begin
          status_d = ple_pkg::ST_FULL;
        end else begin
          op.ins = 1'b1;
        end
      end
      ple_pkg::CMD_DEL_FRONT: begin
        if (empty) begin
          status_d = ple_pkg::ST_UNDERFLOW;
        end else begin
          op.rem = 1'b1;
        end
      end
      ple_pkg::CMD_DEL_REAR: begin
        idx = count_m1[IDX_W-1:0];
        if (empty) begin
          status_d = ple_pkg::ST_UNDERFLOW;
        end else begin
          op.rem = 1'b1;
        end
      end
      ple_pkg::CMD_INS_POS: begin
        idx = pos_m1[IDX_W-1:0];
        // The position check takes priority over the full check.
        if (position_i == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
          status_d = ple_pkg::ST_RANGE;
        end else if (full) begin
          status_d = ple_pkg::ST_FULL;
        end else begin
          op.ins = 1'b1;
        end
      end
      ple_pkg::CMD_DEL_POS: begin
        idx = pos_m1[IDX_W-1:0];
        if (position_i == '0 || pos_ext > cnt_ext) begin
          status_d = ple_pkg::ST_RANGE;
        end else begin
          op.rem = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      op = '0;
    end
  end

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ELEM_WIDTH-1:0] left, right;
      if (i == 0) begin : g_first
        assign left = '0;
      end else begin : g_mid_l
        assign left = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right = cell_data[i];
      end else begin : g_mid_r
        assign right = cell_data[i+1];
      end
      ple_cell #(
        .ELEM_WIDTH(ELEM_WIDTH),
        .IDX_W     (IDX_W),
        .CELL_IDX  (i)
      ) u_cell (
        .clk_i  (clk_i),
        .op_i   (op),
        .idx_i  (idx),
        .value_i(value_i),
        .left_i (left),
        .right_i(right),
        .data_o (cell_data[i]),
        .pick_o (cell_pick[i])
      );
    end
  endgenerate

  always_comb begin
    pick_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      pick_or = pick_or | cell_pick[i];
    end
    removed_d = op.rem ? pick_or : '0;
    count_d   = count_q;
    if (op.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (op.rem) begin
      count_d = count_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      removed_q <= removed_d;
      length_q  <= count_d;
      empty_q   <= (count_d == '0);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign length_o        = length_q;
  assign is_empty_o      = empty_q;

endmodule

### sv/ple_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks of the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ple_checker #(
  parameter int CAPACITY   = ple_pkg::CapacityDef,
  parameter int ELEM_WIDTH = ple_pkg::ElemWidthDef,
  localparam int CNT_W     = $clog2(CAPACITY + 1),
  localparam int POS_W     = $clog2(CAPACITY + 2)
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [2:0]            cmd_i,
  input logic [POS_W-1:0]      position_i,
  input logic [ELEM_WIDTH-1:0] value_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [1:0]            status_o,
  input logic [ELEM_WIDTH-1:0] removed_value_o,
  input logic [CNT_W-1:0]      length_o,
  input logic                  is_empty_o
);

  // The input side only stalls behind a result that is still waiting.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a pending result");

  // An accepted request always yields a result in the next cycle.
  a_request_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted request produced no result");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o)
      && $stable(removed_value_o) && $stable(length_o)))
    else $error("stalled result changed");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((is_empty_o == (length_o == '0))
      && (length_o <= CNT_W'(CAPACITY))))
    else $error("length and empty flag disagree");

  // A failed request never reports a removed element.
  a_fail_no_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ple_pkg::ST_OK) |-> (removed_value_o == '0))
    else $error("removed element reported on a failed request");

endmodule

bind positional_list_engine ple_checker #(
  .CAPACITY  (CAPACITY),
  .ELEM_WIDTH(ELEM_WIDTH)
) u_ple_checker (.*);

### tb/sv/list_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_result_checker
// Watches both channels of the positional list engine and keeps its own copy
// of the element row. For each accepted request it predicts the result, then
// compares each accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module list_result_checker
  import ple_pkg::*;
#(
  parameter int Capacity = CapacityDef,
  parameter int ElemW    = ElemWidthDef,
  parameter int CntW     = $clog2(Capacity + 1),
  parameter int PosW     = $clog2(Capacity + 2)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [2:0]       cmd_i,
  input  logic [PosW-1:0]  position_i,
  input  logic [ElemW-1:0] value_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [1:0]       status_i,
  input  logic [ElemW-1:0] removed_value_i,
  input  logic [CntW-1:0]  length_i,
  input  logic             is_empty_i,
  output int               mismatch_count_o,
  output int               pending_o
);

  typedef struct packed {
    status_e          status;
    logic [ElemW-1:0] removed;
    logic [CntW-1:0]  length;
    logic             is_empty;
  } list_result_t;

  logic [ElemW-1:0] cells [Capacity];
  int unsigned      held = 0;
  list_result_t     expected_results [$];

  task automatic insert_cell(input int unsigned idx, input logic [ElemW-1:0] val);
    for (int unsigned i = held; i > idx; i--) cells[i] = cells[i-1];
    cells[idx] = val;
    held++;
  endtask

  task automatic remove_cell(input int unsigned idx, output logic [ElemW-1:0] val);
    val = cells[idx];
    for (int unsigned i = idx; i + 1 < held; i++) cells[i] = cells[i+1];
    held--;
  endtask

  task automatic predict_list_command(input logic [2:0] cmd, input logic [PosW-1:0] pos,
                                      input logic [ElemW-1:0] val,
                                      output list_result_t res);
    int unsigned p;
    logic [ElemW-1:0] taken;
    p           = 32'(pos);
    taken       = '0;
    res.status  = ST_OK;
    case (cmd)
      CMD_ADD_FRONT, CMD_ADD_REAR: begin
        if (held >= Capacity) res.status = ST_FULL;
        else insert_cell((cmd == CMD_ADD_FRONT) ? 0 : held, val);
      end
      CMD_DEL_FRONT, CMD_DEL_REAR: begin
        if (held == 0) res.status = ST_UNDERFLOW;
        else remove_cell((cmd == CMD_DEL_FRONT) ? 0 : held - 1, taken);
      end
      // The position check takes priority over the full check.
      CMD_INS_POS: begin
        if (p < 1 || p > held + 1) res.status = ST_RANGE;
        else if (held >= Capacity) res.status = ST_FULL;
        else insert_cell(p - 1, val);
      end
      CMD_DEL_POS: begin
        if (p < 1 || p > held) res.status = ST_RANGE;
        else remove_cell(p - 1, taken);
      end
      default: ;
    endcase
    res.removed  = taken;
    res.length   = CntW'(held);
    res.is_empty = (held == 0);
  endtask

  always @(posedge clk_i) begin
    list_result_t want;
    list_result_t got;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        got = '{status: status_e'(status_i), removed: removed_value_i,
                length: length_i, is_empty: is_empty_i};
        if (expected_results.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("list check: unexpected result st %0d rm %h len %0d emp %0b",
                     status_i, removed_value_i, length_i, is_empty_i);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.removed !== want.removed ||
              got.length !== want.length || got.is_empty !== want.is_empty) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10)
              $display("list check: got/want st %0d/%0d rm %h/%h len %0d/%0d emp %0b/%0b",
                       status_i, want.status, removed_value_i, want.removed,
                       length_i, want.length, is_empty_i, want.is_empty);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_list_command(cmd_i, position_i, value_i, want);
        expected_results.push_back(want);
      end
    end
    pending_o = expected_results.size();
  end

endmodule

### tb/sv/positional_list_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_tb
// Drives add, delete and positional requests into the list engine: a directed
// pass over empty, full and bad-position cases, then random requests in fill,
// drain and balanced stretches under several idle and stall patterns.
// ----------------------------------------------------------------------------
module positional_list_engine_tb;
  import ple_pkg::*;

  localparam int Capacity = CapacityDef;
  localparam int ElemW    = ElemWidthDef;
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int PosW     = $clog2(Capacity + 2);
  localparam int CycleLimit = 400000;

  // Spare command codes; the engine must answer them without changing state.
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [2:0]       cmd_i;
  logic [PosW-1:0]  position_i;
  logic [ElemW-1:0] value_i;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [1:0]       status_o;
  logic [ElemW-1:0] removed_value_o;
  logic [CntW-1:0]  length_o;
  logic             is_empty_o;

  int mismatches;
  int pending;
  int send_idle_pct = 0;
  int out_stall_pct = 0;
  int cycles = 0;

  positional_list_engine #(.CAPACITY(Capacity), .ELEM_WIDTH(ElemW)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .cmd_i(cmd_i), .position_i(position_i), .value_i(value_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .status_o(status_o), .removed_value_o(removed_value_o),
    .length_o(length_o), .is_empty_o(is_empty_o)
  );

  list_result_checker #(.Capacity(Capacity), .ElemW(ElemW)) checker_u (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_i(in_stall_o),
    .cmd_i(cmd_i), .position_i(position_i), .value_i(value_i),
    .out_valid_i(out_valid_o), .out_stall_i(out_stall_i),
    .status_i(status_o), .removed_value_i(removed_value_o),
    .length_i(length_o), .is_empty_i(is_empty_o),
    .mismatch_count_o(mismatches), .pending_o(pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
    cycles++;
    if (cycles > CycleLimit) begin
      $display("positional_list_engine_tb: errors");
      $finish;
    end
  end

  // Holds the request until the engine takes it; the stall seen at the falling
  // edge is the one that counts at the next rising edge.
  task automatic send_request(input logic [2:0] cmd, input logic [PosW-1:0] pos,
                              input logic [ElemW-1:0] val);
    int   gap;
    logic stalled;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_i      <= cmd;
    position_i <= pos;
    value_i    <= val;
    in_valid_i <= 1'b1;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
  endtask

  // Random requests in stretches of forty that lean toward filling, draining
  // or holding the list, so both the full and the empty ends are visited.
  task automatic run_random(input int count);
    int              add_pct;
    int              roll;
    int              i;
    logic [2:0]      cmd;
    logic [PosW-1:0] pos;
    add_pct = 50;
    for (i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0:       add_pct = 85;
          1:       add_pct = 15;
          default: add_pct = 50;
        endcase
      end
      roll = $urandom_range(99);
      if (roll < 3) begin
        cmd = $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
      end else if ($urandom_range(99) < add_pct) begin
        case ($urandom_range(2))
          0:       cmd = CMD_ADD_FRONT;
          1:       cmd = CMD_ADD_REAR;
          default: cmd = CMD_INS_POS;
        endcase
      end else begin
        case ($urandom_range(2))
          0:       cmd = CMD_DEL_FRONT;
          1:       cmd = CMD_DEL_REAR;
          default: cmd = CMD_DEL_POS;
        endcase
      end
      roll = $urandom_range(99);
      if (roll < 8) pos = '0;
      else if (roll < 16) pos = PosW'($urandom_range(Capacity + 1, Capacity));
      else if (roll < 58) pos = PosW'($urandom_range(9, 1));
      else pos = PosW'($urandom_range(Capacity + 1, 1));
      send_request(cmd, pos, $urandom);
    end
  endtask

  initial begin
    int i;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    cmd_i       <= CMD_ADD_FRONT;
    position_i  <= '0;
    value_i     <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list: underflow, bad positions and the spare codes.
    send_request(CMD_DEL_FRONT, PosW'(1), '0);
    send_request(CMD_DEL_REAR, PosW'(1), '0);
    send_request(CMD_DEL_POS, PosW'(1), '0);
    send_request(CMD_INS_POS, '0, 32'h1234_5678);
    send_request(CMD_INS_POS, PosW'(2), 32'h1234_5678);
    send_request(CMD_SPARE_A, PosW'(3), 32'hFFFF_FFFF);
    send_request(CMD_SPARE_B, PosW'(17), 32'hFFFF_FFFF);

    // Fill to capacity with extreme and random values.
    send_request(CMD_INS_POS, PosW'(1), '0);
    for (i = 1; i < Capacity; i++)
      send_request((i % 2) ? CMD_ADD_REAR : CMD_ADD_FRONT, '0,
                   (i % 3 == 0) ? 32'hFFFF_FFFF : $urandom);

    // Full list: adds refused, a bad position still reported as out of range, then deletes.
    send_request(CMD_ADD_FRONT, '0, 32'hAAAA_AAAA);
    send_request(CMD_ADD_REAR, '0, 32'h5555_5555);
    send_request(CMD_INS_POS, PosW'(Capacity + 1), 32'h8000_0001);
    send_request(CMD_INS_POS, '0, 32'h8000_0001);
    send_request(CMD_DEL_POS, PosW'(Capacity + 1), '0);
    send_request(CMD_DEL_POS, PosW'(Capacity), '0);
    send_request(CMD_DEL_FRONT, '0, '0);
    send_request(CMD_DEL_REAR, '0, '0);

    run_random(200);
    send_idle_pct = 84;
    out_stall_pct = 0;
    run_random(200);
    send_idle_pct = 0;
    out_stall_pct = 84;
    run_random(200);
    send_idle_pct = 6;
    out_stall_pct = 6;
    run_random(200);

    in_valid_i <= 1'b0;
    // Wait past the edge of the last request so its prediction is counted.
    do @(negedge clk_i); while (pending != 0);
    repeat (5) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("positional_list_engine_tb: clean");
    end else begin
      $display("positional_list_engine_tb: errors");
    end
    $finish;
  end

endmodule

### positional_list_engine.f
sv/ple_pkg.sv
sv/ple_cell.sv
sv/positional_list_engine.sv
sv/ple_checker.sv
tb/sv/list_result_checker.sv
tb/sv/positional_list_engine_tb.sv
